@@ hdl/aoc_pkg.sv @@
// ---------------------------------------------------------------------------
// aoc_pkg: shared types and helpers for the alpha-over composite core
// Pixel payload structs, divider pipeline word and the divide-by-255 helper.
// ---------------------------------------------------------------------------
`default_nettype none

package aoc_pkg;

  // Full-scale channel value.
  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Number of color channels carried through the divider.
  localparam int NUM_CHAN = 3;

  // Pipeline depth: three front stages plus four divider stages.
  localparam int FRONT_STAGES = 3;
  localparam int DIV_STAGES   = 4;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES;

  // Input transfer: one source and one destination pixel.
  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dest_red;
    logic [7:0] dest_green;
    logic [7:0] dest_blue;
    logic [7:0] dest_alpha;
  } pix_in_t;

  // Output transfer: the composited pixel.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  // One channel of the long division. The partial remainder sits in rem;
  // bits holds the numerator bits still to be consumed at its top and the
  // quotient bits already produced at its bottom.
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] bits;
  } chan_div_t;

  // Word that travels down the divider pipeline.
  typedef struct packed {
    chan_div_t [NUM_CHAN-1:0] ch;
    logic [7:0]               oa;
  } div_word_t;

  // floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] s;
    s = x + 16'd1 + {8'h00, x[15:8]};
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

@@ hdl/aoc_front.sv @@
// ---------------------------------------------------------------------------
// aoc_front: weighting front end of the composite pipeline
// Three register stages: destination weight product, weighted destination
// alpha and output alpha, then the per-channel blend numerators.
// ---------------------------------------------------------------------------
`default_nettype none

module aoc_front
  import aoc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic [FRONT_STAGES-1:0] en,
  input  wire pix_in_t                 pix_in,
  output div_word_t                    word_out
);

  // Stage 1 registers.
  logic [15:0] prod1_r;
  logic [15:0] prod1_nxt;
  pix_in_t     pix1_r;

  // Stage 2 registers.
  logic [7:0]  part2_r;
  logic [7:0]  part2_nxt;
  logic [7:0]  oa2_r;
  logic [7:0]  oa2_nxt;
  pix_in_t     pix2_r;

  // Stage 3 register.
  div_word_t   word3_r;
  div_word_t   word3_nxt;

  logic [7:0]  src_c [NUM_CHAN];
  logic [7:0]  dst_c [NUM_CHAN];
  logic [15:0] num   [NUM_CHAN];

  // Stage 1: destination alpha times the source transparency.
  assign prod1_nxt = {8'h00, pix_in.dest_alpha} * {8'h00, CHAN_MAX - pix_in.src_alpha};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod1_r <= prod1_nxt;
      pix1_r  <= pix_in;
    end
  end

  // Stage 2: weighted destination alpha and the output alpha.
  assign part2_nxt = div255(prod1_r);
  assign oa2_nxt   = pix1_r.src_alpha + part2_nxt;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      part2_r <= part2_nxt;
      oa2_r   <= oa2_nxt;
      pix2_r  <= pix1_r;
    end
  end

  // Stage 3: blend numerators, split for the long division.
  assign src_c[0] = pix2_r.src_red;
  assign src_c[1] = pix2_r.src_green;
  assign src_c[2] = pix2_r.src_blue;
  assign dst_c[0] = pix2_r.dest_red;
  assign dst_c[1] = pix2_r.dest_green;
  assign dst_c[2] = pix2_r.dest_blue;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      num[c] = {8'h00, src_c[c]} * {8'h00, pix2_r.src_alpha}
             + {8'h00, dst_c[c]} * {8'h00, part2_r};
      word3_nxt.ch[c].rem  = num[c][15:8];
      word3_nxt.ch[c].bits = num[c][7:0];
    end
    word3_nxt.oa = oa2_r;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      word3_r <= word3_nxt;
    end
  end

  assign word_out = word3_r;

endmodule

`default_nettype wire

@@ hdl/aoc_div_step.sv @@
// ---------------------------------------------------------------------------
// aoc_div_step: one stage of the pipelined restoring divider
// Retires two quotient bits per channel and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module aoc_div_step
  import aoc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      en,
  input  wire div_word_t word_in,
  output div_word_t      word_out
);

  div_word_t word_r;
  div_word_t word_nxt;

  // One restoring step: bring down the next numerator bit, subtract the
  // divisor when it fits, and shift the quotient bit in at the bottom.
  function automatic chan_div_t div_bit(input chan_div_t c, input logic [7:0] d);
    chan_div_t  r;
    logic [8:0] t;
    logic [8:0] diff;
    logic       ge;
    t      = {c.rem, c.bits[7]};
    diff   = t - {1'b0, d};
    ge     = (t >= {1'b0, d});
    r.rem  = ge ? diff[7:0] : t[7:0];
    r.bits = {c.bits[6:0], ge};
    return r;
  endfunction

  // Two bits per stage on every channel.
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      word_nxt.ch[c] = div_bit(div_bit(word_in.ch[c], word_in.oa), word_in.oa);
    end
    word_nxt.oa = word_in.oa;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word_out = word_r;

endmodule

`default_nettype wire

@@ hdl/rgba_alpha_over_composite_core.sv @@
// ---------------------------------------------------------------------------
// rgba_alpha_over_composite_core: source-over-destination RGBA8888 blender
// Composites one non-premultiplied source pixel over one destination pixel.
// ---------------------------------------------------------------------------
// Usage:
//   A pixel pair enters on in_pix when in_valid is high and in_stall is low.
//   The composited pixel leaves on out_pix when out_valid is high and
//   out_stall is low. There is no configuration.
// Pipeline: seven register stages, three front stages (weight product,
//   weighted destination alpha, blend numerators) and four divider stages
//   that each retire two quotient bits.
// Throughput: one pixel per cycle without stalls. Each stage moves forward
//   whenever it is empty or the stage after it moves, so bubbles close up
//   and the input keeps taking transfers while a result waits at the output.
// Stall: a stalled output holds its payload; the stall reaches in_stall only
//   once every stage holds a valid pixel.
// Reset: rst_n clears all valid bits; the pipeline is empty afterwards.
// A fully transparent pair (both alphas zero) gives all-zero output.
// ---------------------------------------------------------------------------
`default_nettype none

module rgba_alpha_over_composite_core
  import aoc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire pix_in_t in_pix,
  output logic         out_valid,
  input  wire logic    out_stall,
  output pix_out_t     out_pix
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] adv;

  div_word_t             word [DIV_STAGES+1];
  logic                  alpha_zero;

  // Stage advance chain: a stage loads when it is empty or its successor
  // moves on.
  always_comb begin
    adv[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  // Valid bits follow the data down the pipeline.
  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        valid_nxt[k] = (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Front end: alpha weighting and blend numerators.
  aoc_front u_front (
    .clk      (clk),
    .en       (adv[FRONT_STAGES-1:0]),
    .pix_in   (in_pix),
    .word_out (word[0])
  );

  // Divider stages.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    aoc_div_step u_step (
      .clk      (clk),
      .en       (adv[FRONT_STAGES+s]),
      .word_in  (word[s]),
      .word_out (word[s+1])
    );
  end

  // Output: a zero output alpha forces the colors to zero.
  assign alpha_zero = (word[DIV_STAGES].oa == 8'd0);

  assign out_valid         = valid_r[NUM_STAGES-1];
  assign out_pix.out_red   = alpha_zero ? 8'd0 : word[DIV_STAGES].ch[0].bits;
  assign out_pix.out_green = alpha_zero ? 8'd0 : word[DIV_STAGES].ch[1].bits;
  assign out_pix.out_blue  = alpha_zero ? 8'd0 : word[DIV_STAGES].ch[2].bits;
  assign out_pix.out_alpha = word[DIV_STAGES].oa;

  // The input stalls only when the whole pipeline is full behind a stalled
  // result.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&valid_r)))
    else $error("input stalled while the pipeline has room");

  // An empty first stage never refuses a transfer.
  a_first_open: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0] |-> !in_stall)
    else $error("empty first stage reports a stall");

  // Every delivered result leaves the divider with a remainder below the
  // divisor on each channel.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !alpha_zero) |->
      ((word[DIV_STAGES].ch[0].rem < word[DIV_STAGES].oa) &&
       (word[DIV_STAGES].ch[1].rem < word[DIV_STAGES].oa) &&
       (word[DIV_STAGES].ch[2].rem < word[DIV_STAGES].oa)))
    else $error("divider remainder not below the output alpha");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for rgba_alpha_over_composite_core
// Pixel pairs are sent through the input handshake with random gaps, and the
// output side stalls at random, except in one full-rate stretch. Each result
// is checked per channel against a behavioral source-over blend of its pair.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import aoc_pkg::*;

  localparam int IDLE_PCT      = 25;
  localparam int SETTLE_CYCLES = 20;
  localparam int STUCK_LIMIT   = 2000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  pix_in_t  in_pix    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pix_out_t out_pix;

  // Composited pixels that are still due at the output, oldest first.
  pix_out_t blended_due[$];
  int       error_count = 0;
  int       stuck_cycles = 0;
  bit       gaps_on = 1'b1;

  rgba_alpha_over_composite_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pix    (in_pix),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Weighted average of one color channel; a zero output alpha gives zero.
  function automatic logic [7:0] mix_chan(input int unsigned sc, input int unsigned dc,
                                          input int unsigned sa, input int unsigned part,
                                          input int unsigned oa);
    if (oa == 0) begin
      return 8'd0;
    end
    return 8'((sc * sa + dc * part) / oa);
  endfunction

  // Source-over blend of one non-premultiplied pixel pair.
  function automatic pix_out_t blend_over(input pix_in_t p);
    pix_out_t    r;
    int unsigned full;
    int unsigned sa;
    int unsigned part;
    int unsigned oa;
    full = 32'(CHAN_MAX);
    sa   = 32'(p.src_alpha);
    part = (32'(p.dest_alpha) * (full - sa)) / full;
    oa   = sa + part;
    r.out_red   = mix_chan(32'(p.src_red),   32'(p.dest_red),   sa, part, oa);
    r.out_green = mix_chan(32'(p.src_green), 32'(p.dest_green), sa, part, oa);
    r.out_blue  = mix_chan(32'(p.src_blue),  32'(p.dest_blue),  sa, part, oa);
    r.out_alpha = 8'(oa);
    return r;
  endfunction

  function automatic pix_in_t random_pair();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] edge_alpha();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("%t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_chan(input string name, input logic [7:0] got,
                            input logic [7:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Output side stalls at random while gaps are enabled.
  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Record each input transfer and check each output transfer.
  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        blended_due.push_back(blend_over(in_pix));
      end
      if (out_valid && !out_stall) begin
        if (blended_due.size() == 0) begin
          report_error("result transfer with no pixel pair pending");
        end else begin
          want = blended_due.pop_front();
          check_chan("red",   out_pix.out_red,   want.out_red);
          check_chan("green", out_pix.out_green, want.out_green);
          check_chan("blue",  out_pix.out_blue,  want.out_blue);
          check_chan("alpha", out_pix.out_alpha, want.out_alpha);
        end
      end
    end
  end

  // Watchdog: ends the run when neither side has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
      $display("[rgba_alpha_over_composite_core] ERROR");
      $finish;
    end
  end

  // Sends one pixel pair; called and returns at a falling edge.
  task automatic send_pair(input pix_in_t p);
    while (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pix   <= p;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Holds the input idle until every pending result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (blended_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Directed pairs: alpha extremes, pass-through and the fully clear pair.
  task automatic test_corners();
    send_pair({8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd0});
    send_pair({8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0});
    send_pair({8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd255});
    send_pair({8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd1});
    send_pair({8'd200, 8'd100, 8'd50, 8'd255, 8'd10, 8'd20, 8'd30, 8'd255});
    send_pair({8'd200, 8'd100, 8'd50, 8'd255, 8'd10, 8'd20, 8'd30, 8'd0});
    send_pair({8'd1, 8'd2, 8'd3, 8'd1, 8'd250, 8'd251, 8'd252, 8'd1});
    send_pair({8'd0, 8'd128, 8'd255, 8'd128, 8'd255, 8'd128, 8'd0, 8'd128});
    send_pair({8'd255, 8'd0, 8'd255, 8'd254, 8'd0, 8'd255, 8'd0, 8'd255});
    send_pair({8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255});
    send_pair('0);
    send_pair('1);
    send_pair({8{8'hAA}});
    send_pair({8{8'h55}});
    send_pair({8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA});
    send_pair({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
  endtask

  // Fully random pairs.
  task automatic test_random_pairs(input int count);
    repeat (count) begin
      send_pair(random_pair());
    end
  endtask

  // Random colors with alphas drawn mostly from the extremes.
  task automatic test_alpha_extremes(input int count);
    pix_in_t p;
    repeat (count) begin
      p = random_pair();
      p.src_alpha  = edge_alpha();
      p.dest_alpha = edge_alpha();
      send_pair(p);
    end
  endtask

  // Bursts separated by a full drain of the pipeline.
  task automatic test_drain_pause();
    repeat (4) begin
      repeat ($urandom_range(30, 10)) begin
        send_pair(random_pair());
      end
      wait_drained();
    end
  endtask

  // Full-rate stretch with no input gaps and no output stalls.
  task automatic test_full_rate(input int count);
    gaps_on = 1'b0;
    test_random_pairs(count);
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) begin
      @(negedge clk);
    end
    rst_n <= 1'b1;
    test_corners();
    test_random_pairs(950);
    test_drain_pause();
    test_full_rate(400);
    test_alpha_extremes(400);
    wait_drained();
    repeat (SETTLE_CYCLES) begin
      @(negedge clk);
    end
    if (blended_due.size() != 0) begin
      report_error($sformatf("%0d results never arrived", blended_due.size()));
    end
    if (error_count == 0) begin
      $display("[rgba_alpha_over_composite_core] OK");
    end else begin
      $display("[rgba_alpha_over_composite_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/aoc_pkg.sv
hdl/aoc_front.sv
hdl/aoc_div_step.sv
hdl/rgba_alpha_over_composite_core.sv
tb/testbench.sv
